// ===== design/lbers_pkg.sv =====
// ----------------------------------------------------------------------------
// lbers_pkg
// Shared types and constants for the LED blink / expander refresh sequencer.
// ----------------------------------------------------------------------------
package lbers_pkg;

  localparam int unsigned LedCount = 4;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_ERROR = 2'd2,
    ACT_MODES = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_START       = 3'd1,
    CMD_SEND        = 3'd2,
    CMD_STOP        = 3'd3,
    CMD_STOP_START  = 3'd4,
    CMD_RESET       = 3'd5,
    CMD_RESET_START = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    SEQ_CONFIG = 3'd0,
    SEQ_INVERT = 3'd1,
    SEQ_OUTPUT = 3'd2,
    SEQ_INPUT  = 3'd3,
    SEQ_DONE   = 3'd4
  } seq_e;

  typedef enum logic [3:0] {
    PH_NONE     = 4'd0,
    PH_W_START  = 4'd1,
    PH_W_ADDR   = 4'd2,
    PH_W_REG    = 4'd3,
    PH_W_DATA   = 4'd4,
    PH_R_START  = 4'd5,
    PH_R_ADDR   = 4'd6,
    PH_R_REG    = 4'd7,
    PH_R_RSTART = 4'd8,
    PH_R_RADDR  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    CFG_TICK   = 3'd0,
    CFG_SLOW   = 3'd1,
    CFG_MEDIUM = 3'd2,
    CFG_FAST   = 3'd3,
    CFG_ADDR   = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_SLOW   = 3'd2,
    MODE_MEDIUM = 3'd3,
    MODE_FAST   = 3'd4
  } mode_e;

  localparam logic [7:0] RegConfig = 8'h06;
  localparam logic [7:0] RegInvert = 8'h04;
  localparam logic [7:0] RegOutput = 8'h02;
  localparam logic [7:0] RegInput  = 8'h00;
  localparam logic [7:0] DirData   = 8'hF0;
  localparam logic [7:0] InvData   = 8'hFF;

  // Classified request between front and back
  typedef struct packed {
    action_e             action;
    logic                start_sent;
    logic                tx_empty;
    logic                rx_not_empty;
    logic [3:0]          rx_nibble;
    logic [LedCount-1:0] led_select;
    logic [2:0]          led_mode;
  } req_t;

endpackage

// ===== design/lbers_front.sv =====
// ----------------------------------------------------------------------------
// lbers_front
// Accepts requests and queues them for the back end (two-entry queue).
// ----------------------------------------------------------------------------
module lbers_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action_i,
  input  logic                 start_sent_i,
  input  logic                 tx_empty_i,
  input  logic                 rx_not_empty_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [3:0]           led_select_i,
  input  logic [2:0]           led_mode_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output lbers_pkg::req_t      q_req_o
);

  lbers_pkg::req_t mem_q [lbers_pkg::QDepth];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  lbers_pkg::req_t req;

  // Classify: pack fields, keep only the switch nibble of rx data
  always_comb begin
    req.action       = lbers_pkg::action_e'(action_i);
    req.start_sent   = start_sent_i;
    req.tx_empty     = tx_empty_i;
    req.rx_not_empty = rx_not_empty_i;
    req.rx_nibble    = rx_byte_i[7:4];
    req.led_select   = led_select_i[lbers_pkg::LedCount-1:0];
    req.led_mode     = led_mode_i;
  end

  assign in_ready  = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = mem_q[rd_ptr_q];
  assign push      = in_valid && in_ready;
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req;
    end
  end

endmodule

// ===== design/lbers_back.sv =====
// ----------------------------------------------------------------------------
// lbers_back
// Executes queued requests: blink counters, LED modes, expander sequencer.
// ----------------------------------------------------------------------------
module lbers_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  lbers_pkg::req_t     q_req_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          bus_command_o,
  output logic [7:0]          tx_byte_o,
  output logic [3:0]          led_pattern_o,
  output logic [3:0]          switch_states_o,
  output logic                error_flag_o
);

  localparam int unsigned LC = lbers_pkg::LedCount;

  logic [9:0]  tick_q;
  logic [15:0] slow_lim_q, med_lim_q, fast_lim_q;
  logic [6:0]  addr_q;

  lbers_pkg::seq_e   seq_q, seq_d;
  lbers_pkg::phase_e ph_q, ph_d;
  logic [15:0] cnt_q [3];
  logic [15:0] cnt_d [3];
  logic [2:0]  phs_q, phs_d;
  logic [2:0]  mode_q [LC];
  logic [2:0]  mode_d [LC];
  logic [3:0]  lit_q, lit_d;
  logic [7:0]  preg_q, preg_d, pdat_q, pdat_d;
  logic [3:0]  sw_q, sw_d;
  logic        err_q, err_d;

  logic        ov_q;
  logic [2:0]  cmd_q, cmd_d;
  logic [7:0]  tx_q, tx_d;

  logic        fire;
  logic [16:0] sum [3];
  logic [15:0] lim [3];
  logic        adv;

  // Output register frees up when empty or being taken
  assign q_ready_o = !ov_q || out_ready;
  assign fire      = q_valid_i && q_ready_o;
  assign lim[0] = slow_lim_q;
  assign lim[1] = med_lim_q;
  assign lim[2] = fast_lim_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= 10'd1;
      slow_lim_q <= 16'd1000;
      med_lim_q  <= 16'd500;
      fast_lim_q <= 16'd250;
      addr_q     <= 7'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        lbers_pkg::CFG_TICK:   tick_q     <= cfg_data[9:0];
        lbers_pkg::CFG_SLOW:   slow_lim_q <= cfg_data;
        lbers_pkg::CFG_MEDIUM: med_lim_q  <= cfg_data;
        lbers_pkg::CFG_FAST:   fast_lim_q <= cfg_data;
        lbers_pkg::CFG_ADDR:   addr_q     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Step logic; adv marks end of a transfer
  always_comb begin
    seq_d  = seq_q;
    ph_d   = ph_q;
    phs_d  = phs_q;
    lit_d  = lit_q;
    preg_d = preg_q;
    pdat_d = pdat_q;
    sw_d   = sw_q;
    err_d  = err_q;
    cmd_d  = lbers_pkg::CMD_NONE;
    tx_d   = 8'h00;
    adv    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cnt_d[i] = cnt_q[i];
      sum[i]   = {1'b0, cnt_q[i]} + {7'd0, tick_q};
    end
    for (int i = 0; i < LC; i++) mode_d[i] = mode_q[i];

    unique case (q_req_i.action)
      lbers_pkg::ACT_TICK: begin
        for (int i = 0; i < 3; i++) begin
          if (sum[i] >= {1'b0, lim[i]}) begin
            cnt_d[i] = 16'd0;
            phs_d[i] = ~phs_q[i];
          end else begin
            cnt_d[i] = sum[i][15:0];
          end
        end
        lit_d = 4'd0;
        for (int i = 0; i < LC; i++) begin
          case (mode_q[i])
            lbers_pkg::MODE_ON:     lit_d[i] = 1'b1;
            lbers_pkg::MODE_SLOW:   lit_d[i] = phs_d[0];
            lbers_pkg::MODE_MEDIUM: lit_d[i] = phs_d[1];
            lbers_pkg::MODE_FAST:   lit_d[i] = phs_d[2];
            default:                lit_d[i] = 1'b0;
          endcase
        end
        if (seq_q == lbers_pkg::SEQ_DONE) begin
          seq_d  = lbers_pkg::SEQ_CONFIG;
          preg_d = lbers_pkg::RegConfig;
          pdat_d = lbers_pkg::DirData;
          ph_d   = lbers_pkg::PH_W_START;
          cmd_d  = err_q ? lbers_pkg::CMD_RESET_START : lbers_pkg::CMD_START;
        end else begin
          cmd_d  = err_q ? lbers_pkg::CMD_RESET : lbers_pkg::CMD_NONE;
        end
      end
      lbers_pkg::ACT_EVENT: begin
        unique case (ph_q)
          lbers_pkg::PH_W_START, lbers_pkg::PH_R_START: if (q_req_i.start_sent) begin
            ph_d  = lbers_pkg::phase_e'(ph_q + 4'd1);
            cmd_d = lbers_pkg::CMD_SEND;
            tx_d  = {addr_q, 1'b0};
          end
          lbers_pkg::PH_W_ADDR, lbers_pkg::PH_R_ADDR: if (q_req_i.tx_empty) begin
            ph_d  = lbers_pkg::phase_e'(ph_q + 4'd1);
            cmd_d = lbers_pkg::CMD_SEND;
            tx_d  = preg_q;
          end
          lbers_pkg::PH_W_REG: if (q_req_i.tx_empty) begin
            ph_d  = lbers_pkg::PH_W_DATA;
            cmd_d = lbers_pkg::CMD_SEND;
            tx_d  = pdat_q;
          end
          lbers_pkg::PH_W_DATA: adv = q_req_i.tx_empty;
          lbers_pkg::PH_R_REG: if (q_req_i.tx_empty) begin
            ph_d  = lbers_pkg::PH_R_RSTART;
            cmd_d = lbers_pkg::CMD_START;
          end
          lbers_pkg::PH_R_RSTART: if (q_req_i.start_sent) begin
            ph_d  = lbers_pkg::PH_R_RADDR;
            cmd_d = lbers_pkg::CMD_SEND;
            tx_d  = {addr_q, 1'b1};
          end
          lbers_pkg::PH_R_RADDR: if (q_req_i.rx_not_empty) begin
            sw_d = q_req_i.rx_nibble;
            adv  = 1'b1;
          end
          default: ;
        endcase
        // Next sequence step
        if (adv) begin
          cmd_d = lbers_pkg::CMD_STOP_START;
          unique case (seq_q)
            lbers_pkg::SEQ_CONFIG: begin
              seq_d  = lbers_pkg::SEQ_INVERT;
              preg_d = lbers_pkg::RegInvert;
              pdat_d = lbers_pkg::InvData;
              ph_d   = lbers_pkg::PH_W_START;
            end
            lbers_pkg::SEQ_INVERT: begin
              seq_d  = lbers_pkg::SEQ_OUTPUT;
              preg_d = lbers_pkg::RegOutput;
              pdat_d = {4'hF, ~lit_q};
              ph_d   = lbers_pkg::PH_W_START;
            end
            lbers_pkg::SEQ_OUTPUT: begin
              seq_d  = lbers_pkg::SEQ_INPUT;
              preg_d = lbers_pkg::RegInput;
              ph_d   = lbers_pkg::PH_R_START;
            end
            default: begin
              seq_d = lbers_pkg::SEQ_DONE;
              err_d = 1'b0;
              ph_d  = lbers_pkg::PH_NONE;
              cmd_d = lbers_pkg::CMD_STOP;
            end
          endcase
        end
      end
      lbers_pkg::ACT_ERROR: err_d = 1'b1;
      default: begin
        for (int i = 0; i < LC; i++)
          if (q_req_i.led_select[i]) mode_d[i] = q_req_i.led_mode;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= lbers_pkg::SEQ_DONE;
      ph_q   <= lbers_pkg::PH_NONE;
      phs_q  <= 3'd0;
      lit_q  <= 4'd0;
      preg_q <= 8'd0;
      pdat_q <= 8'd0;
      sw_q   <= 4'd0;
      err_q  <= 1'b0;
      ov_q   <= 1'b0;
      for (int i = 0; i < 3; i++) cnt_q[i] <= 16'd0;
      for (int i = 0; i < LC; i++) mode_q[i] <= lbers_pkg::MODE_OFF;
    end else begin
      if (fire) begin
        seq_q  <= seq_d;
        ph_q   <= ph_d;
        phs_q  <= phs_d;
        lit_q  <= lit_d;
        preg_q <= preg_d;
        pdat_q <= pdat_d;
        sw_q   <= sw_d;
        err_q  <= err_d;
        cnt_q  <= cnt_d;
        mode_q <= mode_d;
        ov_q   <= 1'b1;
      end else if (out_ready) begin
        ov_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q <= cmd_d;
      tx_q  <= tx_d;
    end
  end

  assign out_valid       = ov_q;
  assign bus_command_o   = cmd_q;
  assign tx_byte_o       = tx_q;
  assign led_pattern_o   = lit_q;
  assign switch_states_o = sw_q;
  assign error_flag_o    = err_q;

endmodule

// ===== design/led_blink_expander_refresh_sequencer_unit.sv =====
// Path: a request is queued into the front queue at the accepting edge and
// executed into the output register when the back end takes it from the queue.
// Throughput: one request per cycle unless a full, untaken output register stalls it.
// Reset: asynchronous active low; state, counters and LED modes clear,
// config registers take their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// led_blink_expander_refresh_sequencer_unit
// Blink counters, LED modes and IO expander refresh sequencer, top level.
// ----------------------------------------------------------------------------
module led_blink_expander_refresh_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action_i,
  input  logic        start_sent_i,
  input  logic        tx_empty_i,
  input  logic        rx_not_empty_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [3:0]  led_select_i,
  input  logic [2:0]  led_mode_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  bus_command_o,
  output logic [7:0]  tx_byte_o,
  output logic [3:0]  led_pattern_o,
  output logic [3:0]  switch_states_o,
  output logic        error_flag_o
);

  logic            q_valid, q_ready;
  lbers_pkg::req_t q_req;

  lbers_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .action_i, .start_sent_i, .tx_empty_i,
    .rx_not_empty_i, .rx_byte_i, .led_select_i, .led_mode_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  lbers_back u_back (
    .clk_i, .rst_ni, .cfg_we, .cfg_index, .cfg_data,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid, .out_ready, .bus_command_o, .tx_byte_o, .led_pattern_o,
    .switch_states_o, .error_flag_o
  );

endmodule
